// ----- hdl/fourteen_segment_lcd_writer_assert.svh -----
// Assertion macros for the 14-segment LCD writer checks.
`ifndef FOURTEEN_SEGMENT_LCD_WRITER_ASSERT_SVH
`define FOURTEEN_SEGMENT_LCD_WRITER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define FSLW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define FSLW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fslw_pkg.sv -----
// Shared constants and glyph table for the 14-segment LCD writer.
`default_nettype none

package fslw_pkg;

  localparam int unsigned ShadowW  = 24;
  localparam int unsigned NumLines = 4;
  localparam logic [7:0]  NumCodes = 8'h60;
  localparam logic [2:0]  NumPos   = 3'd6;
  localparam logic [3:0]  LastIdx  = 4'd13;
  localparam logic [4:0]  ColTopA  = 5'd23;
  localparam logic [4:0]  ColTopB  = 5'd22;

  typedef logic [ShadowW-1:0] line_t;

  // Mask bits 0..13 are segments A..Q, bit 14 decimal point, bit 15 colon.
  function automatic logic [15:0] glyph(input logic [7:0] code);
    logic [15:0] m;
    case (code)
      8'h2A: m = 16'h3FC0;
      8'h2B: m = 16'h1540;
      8'h2D: m = 16'h0440;
      8'h2E: m = 16'h4000;
      8'h2F: m = 16'h2200;
      8'h30: m = 16'h003F;
      8'h31: m = 16'h0006;
      8'h32: m = 16'h045B;
      8'h33: m = 16'h044F;
      8'h34: m = 16'h0466;
      8'h35: m = 16'h046D;
      8'h36: m = 16'h047D;
      8'h37: m = 16'h2201;
      8'h38: m = 16'h047F;
      8'h39: m = 16'h046F;
      8'h3A: m = 16'h8000;
      8'h41: m = 16'h0477;
      8'h42: m = 16'h047C;
      8'h43: m = 16'h0039;
      8'h44: m = 16'h045E;
      8'h45: m = 16'h0479;
      8'h46: m = 16'h0471;
      8'h47: m = 16'h043D;
      8'h48: m = 16'h0476;
      8'h49: m = 16'h1109;
      8'h4A: m = 16'h001E;
      8'h4B: m = 16'h1B00;
      8'h4C: m = 16'h0038;
      8'h4D: m = 16'h02B6;
      8'h4E: m = 16'h08B6;
      8'h4F: m = 16'h003F;
      8'h50: m = 16'h0473;
      8'h51: m = 16'h0467;
      8'h52: m = 16'h0C73;
      8'h53: m = 16'h046D;
      8'h54: m = 16'h1101;
      8'h55: m = 16'h003E;
      8'h56: m = 16'h0886;
      8'h57: m = 16'h2836;
      8'h58: m = 16'h2A80;
      8'h59: m = 16'h1280;
      8'h5A: m = 16'h2209;
      8'h5C: m = 16'h0880;
      8'h5F: m = 16'h0008;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fourteen_segment_lcd_writer.sv -----
// Top level: 14-segment character writer feeding packed LCD RAM bytes.
`default_nettype none

// Each accepted character word updates four 24-bit common-line shadow
// registers and then streams the fourteen LCD RAM bytes (index 0..13, last
// on 13), one per cycle while out_stall_i is low; the byte serializer sets
// that rate. When the block is idle, a word accepted at the input is first
// registered and then loads the shadow registers, after which the first
// byte is presented. An input register
// holds the next word while the current run drains and it is applied the
// cycle the last byte is taken. Words with a code of 0x60 or above or a
// position of 6 or 7 are dropped without effect and without output.
module fourteen_segment_lcd_writer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] position_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic       clear_first_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      ram_index_o,
  output logic [7:0]      ram_byte_o,
  output logic            last_o
);

  logic       in_vld_q;
  logic [2:0] pos_q;
  logic [7:0] sym_q;
  logic       clr_q;

  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  fslw_pkg::line_t [fslw_pkg::NumLines-1:0] shadow_q, shadow_d;

  logic        bad;
  logic        emit_free;
  logic        consume;
  logic        load;
  logic        out_take;
  logic [15:0] m;
  logic [4:0]  c1, c2, c3, c4;
  fslw_pkg::line_t oh1, oh2, oh3, oh4, keep;

  assign out_take  = busy_q && !out_stall_i;
  assign emit_free = !busy_q || (out_take && cnt_q == fslw_pkg::LastIdx);
  assign bad       = (sym_q >= fslw_pkg::NumCodes) || (pos_q >= fslw_pkg::NumPos);
  assign consume   = in_vld_q && (bad || emit_free);
  assign load      = in_vld_q && !bad && emit_free;
  assign in_stall_o = in_vld_q && !consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (consume) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pos_q <= position_i;
      sym_q <= symbol_i;
      clr_q <= clear_first_i;
    end
  end

  // Four segment columns per digit: two from each end of the line.
  assign m   = fslw_pkg::glyph(sym_q);
  assign c1  = {1'b0, pos_q, 1'b0};
  assign c2  = c1 + 5'd1;
  assign c3  = fslw_pkg::ColTopA - c1;
  assign c4  = fslw_pkg::ColTopB - c1;
  assign oh1 = fslw_pkg::line_t'(1) << c1;
  assign oh2 = fslw_pkg::line_t'(1) << c2;
  assign oh3 = fslw_pkg::line_t'(1) << c3;
  assign oh4 = fslw_pkg::line_t'(1) << c4;
  assign keep = clr_q ? ~(oh1 | oh2 | oh3 | oh4) : '1;

  always_comb begin
    shadow_d = shadow_q;
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    if (out_take) begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == fslw_pkg::LastIdx) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shadow_d[0] = (shadow_q[0] & keep) | ({24{m[4]}} & oh1) | ({24{m[10]}} & oh2)
                  | ({24{m[6]}} & oh3) | ({24{m[1]}} & oh4);
      shadow_d[1] = (shadow_q[1] & keep) | ({24{m[3]}} & oh1) | ({24{m[2]}} & oh2)
                  | ({24{m[5]}} & oh3) | ({24{m[0]}} & oh4);
      shadow_d[2] = (shadow_q[2] & keep) | ({24{m[12]}} & oh1) | ({24{m[15]}} & oh2)
                  | ({24{m[13]}} & oh3) | ({24{m[9]}} & oh4);
      shadow_d[3] = (shadow_q[3] & keep) | ({24{m[11]}} & oh1) | ({24{m[14]}} & oh2)
                  | ({24{m[7]}} & oh3) | ({24{m[8]}} & oh4);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      shadow_q <= '0;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      shadow_q <= shadow_d;
    end
  end

  // Byte packing: lines 0/1 and 2/3 each fill seven bytes; zero nibbles pad bytes 3, 6, 10 and 13.
  always_comb begin
    case (cnt_q)
      4'd0:    ram_byte_o = shadow_q[0][7:0];
      4'd1:    ram_byte_o = shadow_q[0][15:8];
      4'd2:    ram_byte_o = shadow_q[0][23:16];
      4'd3:    ram_byte_o = {shadow_q[1][3:0], 4'h0};
      4'd4:    ram_byte_o = shadow_q[1][11:4];
      4'd5:    ram_byte_o = shadow_q[1][19:12];
      4'd6:    ram_byte_o = {4'h0, shadow_q[1][23:20]};
      4'd7:    ram_byte_o = shadow_q[2][7:0];
      4'd8:    ram_byte_o = shadow_q[2][15:8];
      4'd9:    ram_byte_o = shadow_q[2][23:16];
      4'd10:   ram_byte_o = {shadow_q[3][3:0], 4'h0};
      4'd11:   ram_byte_o = shadow_q[3][11:4];
      4'd12:   ram_byte_o = shadow_q[3][19:12];
      4'd13:   ram_byte_o = {4'h0, shadow_q[3][23:20]};
      default: ram_byte_o = 8'h00;
    endcase
  end

  assign out_valid_o = busy_q;
  assign ram_index_o = cnt_q;
  assign last_o      = (cnt_q == fslw_pkg::LastIdx);

endmodule

`default_nettype wire

// ----- hdl/fslw_checker.sv -----
// Port-level checks for the 14-segment LCD writer, bound to the top level.
`default_nettype none
`include "fourteen_segment_lcd_writer_assert.svh"

module fslw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] ram_index_o,
  input wire logic [7:0] ram_byte_o,
  input wire logic       last_o
);

  `FSLW_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(ram_index_o) && $stable(ram_byte_o) && $stable(last_o), "stalled word changed")
  `FSLW_ASSERT_IMP(a_last_idx, out_valid_o, last_o == (ram_index_o == fslw_pkg::LastIdx), "last flag does not match index 13")
  `FSLW_ASSERT_NXT(a_run_next, out_valid_o && !out_stall_i && !last_o, out_valid_o && ram_index_o == $past(ram_index_o) + 4'd1, "byte run broken or out of order")
  `FSLW_ASSERT_NXT(a_run_start, out_valid_o && !out_stall_i && last_o, !out_valid_o || ram_index_o == 4'd0, "new run does not start at byte 0")

endmodule

bind fourteen_segment_lcd_writer fslw_checker u_fslw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ram_index_o (ram_index_o),
  .ram_byte_o  (ram_byte_o),
  .last_o      (last_o)
);

`default_nettype wire

// ----- tb/sv/fourteen_segment_lcd_writer_tb.sv -----
// Self-checking testbench for the 14-segment LCD writer: random and directed words.
`timescale 1ns / 1ps

module fourteen_segment_lcd_writer_tb;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] position_i = '0;
  logic [7:0] symbol_i = '0;
  logic       clear_first_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] ram_index_o;
  logic [7:0] ram_byte_o;
  logic       last_o;

  fourteen_segment_lcd_writer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .position_i   (position_i),
    .symbol_i     (symbol_i),
    .clear_first_i(clear_first_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ram_index_o  (ram_index_o),
    .ram_byte_o   (ram_byte_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Segment masks for codes 0x00..0x5F: bits 0..13 segments, 14 point, 15 colon.
  localparam logic [15:0] GlyphMask [96] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h3FC0, 16'h1540, 16'h0000, 16'h0440, 16'h4000, 16'h2200,
    16'h003F, 16'h0006, 16'h045B, 16'h044F, 16'h0466, 16'h046D, 16'h047D, 16'h2201,
    16'h047F, 16'h046F, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0477, 16'h047C, 16'h0039, 16'h045E, 16'h0479, 16'h0471, 16'h043D,
    16'h0476, 16'h1109, 16'h001E, 16'h1B00, 16'h0038, 16'h02B6, 16'h08B6, 16'h003F,
    16'h0473, 16'h0467, 16'h0C73, 16'h046D, 16'h1101, 16'h003E, 16'h0886, 16'h2836,
    16'h2A80, 16'h1280, 16'h2209, 16'h0000, 16'h0880, 16'h0000, 16'h0000, 16'h0008
  };

  typedef struct packed {
    logic [3:0] index;
    logic [7:0] data;
    logic       last;
  } ram_write_t;

  class lcd_ram_scoreboard;
    fslw_pkg::line_t common_lines [fslw_pkg::NumLines];
    ram_write_t      pending_writes [$];
    int              mismatches;

    function new();
      foreach (common_lines[i]) common_lines[i] = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted word to the shadow lines and queue the 14 RAM bytes; out-of-range words are ignored.
    function void note_word(logic [2:0] pos, logic [7:0] sym, logic clr);
      logic [15:0] m;
      int          c1, c2, c3, c4;
      logic [55:0] bank [2];
      ram_write_t  w;
      if (sym >= fslw_pkg::NumCodes || pos >= fslw_pkg::NumPos) return;
      m  = GlyphMask[sym];
      c1 = 2 * int'(pos);
      c2 = c1 + 1;
      c3 = int'(fslw_pkg::ColTopA) - 2 * int'(pos);
      c4 = c3 - 1;
      if (clr) begin
        foreach (common_lines[i]) begin
          common_lines[i][c1] = 1'b0;
          common_lines[i][c2] = 1'b0;
          common_lines[i][c3] = 1'b0;
          common_lines[i][c4] = 1'b0;
        end
      end
      common_lines[0][c4] |= m[1];
      common_lines[0][c1] |= m[4];
      common_lines[0][c3] |= m[6];
      common_lines[0][c2] |= m[10];
      common_lines[1][c4] |= m[0];
      common_lines[1][c2] |= m[2];
      common_lines[1][c1] |= m[3];
      common_lines[1][c3] |= m[5];
      common_lines[2][c4] |= m[9];
      common_lines[2][c1] |= m[12];
      common_lines[2][c3] |= m[13];
      common_lines[2][c2] |= m[15];
      common_lines[3][c3] |= m[7];
      common_lines[3][c4] |= m[8];
      common_lines[3][c1] |= m[11];
      common_lines[3][c2] |= m[14];
      // Line pairs pack into 7 bytes each; the nibble above a 24-bit line is zero.
      bank[0] = {4'h0, common_lines[1], 4'h0, common_lines[0]};
      bank[1] = {4'h0, common_lines[3], 4'h0, common_lines[2]};
      for (int k = 0; k < 14; k++) begin
        w.index = 4'(k);
        w.data  = bank[k / 7][8 * (k % 7) +: 8];
        w.last  = (w.index == fslw_pkg::LastIdx);
        pending_writes.push_back(w);
      end
    endfunction

    function void check_write(logic [3:0] idx, logic [7:0] data, logic last);
      ram_write_t w;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected RAM byte: index %0d data %h last %b", idx, data, last);
        return;
      end
      w = pending_writes.pop_front();
      if (w.index !== idx || w.data !== data || w.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("RAM byte mismatch: expected index %0d data %h last %b, got %0d %h %b",
                   w.index, w.data, w.last, idx, data, last);
      end
    endfunction
  endclass

  lcd_ram_scoreboard sb = new();

  bit random_phase = 1'b0;
  bit held_off = 1'b0;
  int burst_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_write(ram_index_o, ram_byte_o, last_o);
      if (in_valid_i && !in_stall_o) sb.note_word(position_i, symbol_i, clear_first_i);
    end
  end

  // Offer one word, inserting a random gap at each burst boundary.
  task automatic offer_character(input logic [2:0] pos, input logic [7:0] sym,
                                 input logic clr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    position_i    <= pos;
    symbol_i      <= sym;
    clear_first_i <= clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver: stall patterns in random stretches, plus one long hold-off.
  initial begin : receiver
    int mode;
    int span;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (random_phase && !held_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        held_off = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 80);
        repeat (span) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ~out_stall_i;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int          placed;
    logic [2:0]  pos;
    logic [7:0]  sym;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_character(3'd0, 8'h38, 1'b1);
    offer_character(3'd5, 8'h2A, 1'b0);
    offer_character(3'd5, 8'h3A, 1'b0);  // colon
    offer_character(3'd3, 8'h2E, 1'b0);  // decimal point
    offer_character(3'd2, 8'h5F, 1'b1);  // top of table
    offer_character(3'd1, 8'h00, 1'b0);  // blank, no clear: bytes still sent
    offer_character(3'd5, 8'h20, 1'b1);  // blank with clear wipes the digit
    offer_character(3'd4, 8'h60, 1'b1);  // first code past the table
    offer_character(3'd4, 8'hFF, 1'b0);
    offer_character(3'd6, 8'h41, 1'b1);  // positions past the last digit
    offer_character(3'd7, 8'h5A, 1'b0);
    offer_character(3'd4, 8'h4D, 1'b1);
    offer_character(3'd0, 8'h00, 1'b1);
    offer_character(3'd1, 8'h57, 1'b0);
    offer_character(3'd2, 8'h80, 1'b1);
    offer_character(3'd3, 8'h4B, 1'b1);
    offer_character(3'd0, 8'h7F, 1'b0);

    random_phase = 1'b1;
    placed = 0;
    while (placed < 133) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          pos = 3'($urandom_range(6, 7));
          sym = 8'($urandom_range(0, 255));
        end else begin
          pos = 3'($urandom_range(0, 7));
          sym = 8'($urandom_range(96, 255));
        end
      end else begin
        pos = 3'($urandom_range(0, 5));
        sym = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 95)
                                              : $urandom_range(32, 95));
      end
      offer_character(pos, sym, 1'($urandom_range(0, 1)));
      placed++;
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
      $display("fourteen_segment_lcd_writer_tb OK");
    end else begin
      $display("fourteen_segment_lcd_writer_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("fourteen_segment_lcd_writer_tb NOT OK");
    $finish;
  end

endmodule
